// ===== sv/sk128_pkg.sv =====
// -----------------------------------------------------------------------------
// SKINNY-128 shared definitions
// Word widths, mode codes and the forward and inverse round functions.
// -----------------------------------------------------------------------------
`default_nettype none

package sk128_pkg;

   localparam int MAX_ROUNDS = 56;
   localparam int ADDR_W     = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int COUNT_W    = $clog2(MAX_ROUNDS + 1);

   localparam int MODE_W  = 2;
   localparam int SLOT_W  = 6;
   localparam int WORD_W  = 64;
   localparam int COUNT_REG_W = 6;

   localparam logic [COUNT_REG_W-1:0] ROUND_COUNT_RESET = 6'd40;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_ENC  = 2'd1,
      MODE_DEC  = 2'd2
   } mode_type;

   function automatic logic [31:0] rot_cells(input logic [31:0] x, input int unsigned n);
      rot_cells = (x << n) | (x >> (32 - n));
   endfunction

   // Bit-sliced 8-bit S-box on four cells at once
   function automatic logic [31:0] sbox_word(input logic [31:0] xi);
      logic [31:0] x;
      logic [31:0] y;
      x = xi;
      x = x ^ ((~((x >> 2) | (x >> 3))) & 32'h1111_1111);
      y = (~((x << 5) | (x << 1))) & 32'h2020_2020;
      x = x ^ (((~((x << 5) | (x << 4))) & 32'h4040_4040) ^ y);
      y = (~((x << 2) | (x << 1))) & 32'h8080_8080;
      x = x ^ (((~((x >> 2) | (x << 1))) & 32'h0202_0202) ^ y);
      y = (~((x >> 5) | (x << 1))) & 32'h0404_0404;
      x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h0808_0808) ^ y);
      sbox_word = ((x & 32'h0808_0808) << 1) | ((x & 32'h3232_3232) << 2) |
                  ((x & 32'h0101_0101) << 5) | ((x & 32'h8080_8080) >> 6) |
                  ((x & 32'h4040_4040) >> 4) | ((x & 32'h0404_0404) >> 2);
   endfunction

   function automatic logic [31:0] inv_sbox_word(input logic [31:0] xi);
      logic [31:0] x;
      logic [31:0] y;
      x = xi;
      y = (~((x >> 1) | (x >> 3))) & 32'h0101_0101;
      x = x ^ (((~((x >> 2) | (x >> 3))) & 32'h1010_1010) ^ y);
      y = (~((x >> 6) | (x >> 1))) & 32'h0202_0202;
      x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h0808_0808) ^ y);
      y = (~((x << 2) | (x << 1))) & 32'h8080_8080;
      x = x ^ (((~((x >> 1) | (x << 2))) & 32'h0404_0404) ^ y);
      y = (~((x << 5) | (x << 1))) & 32'h2020_2020;
      x = x ^ (((~((x << 4) | (x << 5))) & 32'h4040_4040) ^ y);
      inv_sbox_word = ((x & 32'h0101_0101) << 2) | ((x & 32'h0404_0404) << 4) |
                      ((x & 32'h0202_0202) << 6) | ((x & 32'h2020_2020) >> 5) |
                      ((x & 32'hC8C8_C8C8) >> 2) | ((x & 32'h1010_1010) >> 1);
   endfunction

   // State packed as {row3, row2, row1, row0}
   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [63:0] k);
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [31:0] r3;
      logic [31:0] t;
      r0 = sbox_word(s[31:0]);
      r1 = sbox_word(s[63:32]);
      r2 = sbox_word(s[95:64]);
      r3 = sbox_word(s[127:96]);
      r0 = r0 ^ k[31:0];
      r1 = r1 ^ k[63:32];
      r2 = r2 ^ 32'h0000_0002;
      r1 = rot_cells(r1, 8);
      r2 = rot_cells(r2, 16);
      r3 = rot_cells(r3, 24);
      r1 = r1 ^ r2;
      r2 = r2 ^ r0;
      t  = r3 ^ r2;
      enc_round = {r2, r1, r0, t};
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [63:0] k);
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [31:0] r3;
      logic [31:0] t;
      t  = s[127:96];
      r3 = s[31:0];
      r0 = s[63:32];
      r1 = s[95:64];
      r3 = r3 ^ t;
      r2 = t ^ r0;
      r1 = r1 ^ r2;
      r1 = rot_cells(r1, 24);
      r2 = rot_cells(r2, 16);
      r3 = rot_cells(r3, 8);
      r0 = r0 ^ k[31:0];
      r1 = r1 ^ k[63:32];
      r2 = r2 ^ 32'h0000_0002;
      dec_round = {inv_sbox_word(r3), inv_sbox_word(r2), inv_sbox_word(r1),
                   inv_sbox_word(r0)};
   endfunction

endpackage

`default_nettype wire

// ===== sv/sk128_req_if.sv =====
// -----------------------------------------------------------------------------
// SKINNY-128 request channel
// Carries load, encrypt and decrypt words into the core.
// -----------------------------------------------------------------------------
`default_nettype none

interface sk128_req_if;
   import sk128_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SLOT_W-1:0] round_slot;
   logic [WORD_W-1:0] subkey_word;
   logic [WORD_W-1:0] block_low;
   logic [WORD_W-1:0] block_high;

   modport source (output valid, mode, round_slot, subkey_word, block_low, block_high,
                   input ready);
   modport sink   (input valid, mode, round_slot, subkey_word, block_low, block_high,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/sk128_rsp_if.sv =====
// -----------------------------------------------------------------------------
// SKINNY-128 response channel
// Carries one processed block out of the core.
// -----------------------------------------------------------------------------
`default_nettype none

interface sk128_rsp_if;
   import sk128_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_low;
   logic [WORD_W-1:0] result_high;

   modport source (output valid, result_low, result_high, input ready);
   modport sink   (input valid, result_low, result_high, output ready);
endinterface

`default_nettype wire

// ===== sv/sk128_csr_if.sv =====
// -----------------------------------------------------------------------------
// SKINNY-128 configuration channel
// Carries the round count register write word.
// -----------------------------------------------------------------------------
`default_nettype none

interface sk128_csr_if;
   import sk128_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COUNT_REG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/skinny128_block_cipher_core.sv =====
// -----------------------------------------------------------------------------
// SKINNY-128 block cipher core
// Runs n rounds per block, n = saturated round count: one round per cycle on a
// shared round unit. No new request is accepted while a block is in flight.
// Reset is synchronous: round count returns to 40, the subkey table is left
// undefined until loaded.
// -----------------------------------------------------------------------------
`default_nettype none

module skinny128_block_cipher_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sk128_req_if.sink  req,
   sk128_rsp_if.source rsp,
   sk128_csr_if.sink  csr
);
   import sk128_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Controller state and registered outputs
   state_type                 state_ff,     state_in;
   logic                      dec_ff,       dec_in;
   logic [COUNT_W-1:0]        left_ff,      left_in;
   logic [ADDR_W-1:0]         addr_ff,      addr_in;
   logic [127:0]              block_ff,     block_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [127:0]              result_ff,    result_in;
   logic [COUNT_REG_W-1:0]    round_count_ff;

   // Subkey table, one write port and one registered read port
   logic [WORD_W-1:0]         key_mem [MAX_ROUNDS];
   logic [WORD_W-1:0]         key_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      mem_we;

   logic                      req_take;
   logic [COUNT_W-1:0]        rounds;
   logic [ADDR_W-1:0]         addr_step;
   logic [127:0]              round_out;

   assign req.ready   = (state_ff == ST_IDLE);
   assign req_take    = req.valid & req.ready;
   assign csr.ready   = 1'b1;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_low  = result_ff[63:0];
   assign rsp.result_high = result_ff[127:64];

   // Clamp the round count to the table depth
   always_comb begin
      if (int'(round_count_ff) > MAX_ROUNDS) begin
         rounds = COUNT_W'(MAX_ROUNDS);
      end else begin
         rounds = COUNT_W'(round_count_ff);
      end
   end

   // Shared round unit: forward or inverse round against the registered subkey word
   always_comb begin
      if (dec_ff) begin
         round_out = dec_round(block_ff, key_ff);
      end else begin
         round_out = enc_round(block_ff, key_ff);
      end
   end

   // Encrypt walks the table upwards, decrypt downwards
   assign addr_step = dec_ff ? (addr_ff - ADDR_W'(1)) : (addr_ff + ADDR_W'(1));

   always_comb begin
      state_in     = state_ff;
      dec_in       = dec_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      block_in     = block_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      rd_addr      = addr_ff;
      mem_we       = 1'b0;

      // Drop the response word once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Prefetch the first subkey of whichever direction is requested
            if (mode_type'(req.mode) == MODE_DEC) begin
               rd_addr = ADDR_W'(rounds - COUNT_W'(1));
            end else begin
               rd_addr = '0;
            end
            if (req_take) begin
               unique case (mode_type'(req.mode))
                  MODE_LOAD: begin
                     mem_we = (int'(req.round_slot) < MAX_ROUNDS);
                  end
                  MODE_ENC, MODE_DEC: begin
                     state_in = ST_RUN;
                     dec_in   = (mode_type'(req.mode) == MODE_DEC);
                     left_in  = rounds;
                     addr_in  = rd_addr;
                     block_in = {req.block_high, req.block_low};
                  end
                  default: begin
                     // Unknown mode: accept and drop
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (left_ff != '0) begin
               // Apply one round and fetch the next subkey
               block_in = round_out;
               left_in  = left_ff - COUNT_W'(1);
               addr_in  = addr_step;
               rd_addr  = addr_step;
            end else if (!rsp_valid_ff || rsp.ready) begin
               // Hand the block to the output register; hold here while it is full
               rsp_valid_in = 1'b1;
               result_in    = block_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dec_ff       <= 1'b0;
         left_ff      <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dec_ff       <= dec_in;
         left_ff      <= left_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      block_ff  <= block_in;
      result_ff <= result_in;
   end

   // Round count register
   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_COUNT_RESET;
      end else if (csr.valid && csr.ready) begin
         round_count_ff <= csr.data;
      end
   end

   // Subkey table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[req.round_slot[ADDR_W-1:0]] <= req.subkey_word;
      end
      key_ff <= key_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_busy_not_ready : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req.ready)
      else $error("request accepted while a block is in flight");

   a_left_bounded : assert property (@(posedge clock) disable iff (reset)
      (int'(left_ff) <= MAX_ROUNDS))
      else $error("round counter beyond table depth");

   a_left_counts : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && left_ff != '0) |=> (left_ff == $past(left_ff) - COUNT_W'(1)))
      else $error("round counter did not advance");

   a_start_run : assert property (@(posedge clock) disable iff (reset)
      (req_take && (mode_type'(req.mode) == MODE_ENC || mode_type'(req.mode) == MODE_DEC))
      |=> (state_ff == ST_RUN && left_ff == $past(rounds)))
      else $error("block request did not start the round sequence");

   a_result_on_finish : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && left_ff == '0 && (!rsp_valid_ff || rsp.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished block not posted to the response register");
`endif

endmodule

`default_nettype wire
